FILE: rtl/core/hid_descriptor_run_builder_core_defines.svh
// Assertion macros shared by the run builder RTL.
`ifndef HID_DESCRIPTOR_RUN_BUILDER_CORE_DEFINES_SVH
`define HID_DESCRIPTOR_RUN_BUILDER_CORE_DEFINES_SVH

// Same-cycle implication, checked at every rising clock edge out of reset.
`define HDRB_ASSERT_IMPLIES(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked at every rising clock edge out of reset.
`define HDRB_ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: rtl/core/hid_drb_pkg.sv
package hid_drb_pkg;

    // Field widths of the result stream.
    localparam int unsigned USAGE_W   = 16;
    localparam int unsigned DEST_W    = 16;
    localparam int unsigned LEN_W     = 8;
    localparam int unsigned BYTES_W   = 14;
    localparam int unsigned TDATA_W   = 56;

    // Result queue depth; two entries must be free before a byte is taken.
    localparam int unsigned QUEUE_DEPTH = 4;
    localparam int unsigned QPTR_W      = 2;
    localparam int unsigned QCNT_W      = 3;

    // Item type field (header bits 3:2).
    typedef enum logic [1:0] {
        ITEM_MAIN     = 2'b00,
        ITEM_GLOBAL   = 2'b01,
        ITEM_LOCAL    = 2'b10,
        ITEM_RESERVED = 2'b11
    } item_type_t;

    // Item tags (header bits 7:2, type bits included).
    localparam logic [5:0] INPUT_TAG        = 6'h20;
    localparam logic [5:0] REPORT_COUNT_TAG = 6'h25;
    localparam logic [5:0] USAGE_MIN_TAG    = 6'h06;

    // Size code of four value bytes.
    localparam logic [1:0] SIZE_CODE_FOUR = 2'b11;

    // Input main item flag bits.
    localparam int unsigned CONST_FLAG_BIT = 0;
    localparam int unsigned VAR_FLAG_BIT   = 1;

    // Result kinds carried on tuser.
    typedef enum logic {
        KIND_RUN = 1'b0,
        KIND_END = 1'b1
    } kind_t;

    typedef struct packed {
        kind_t                kind;
        logic [USAGE_W-1:0]   source_start;
        logic [DEST_W-1:0]    dest_start;
        logic [LEN_W-1:0]     run_length;
        logic [BYTES_W-1:0]   bitmap_bytes;
        logic                 last_of_run;
    } result_t;

    // Results produced by one descriptor byte, run first.
    typedef struct packed {
        logic    run_valid;
        logic    end_valid;
        result_t run_res;
        result_t end_res;
    } dec_out_t;

    // Decoder status seen by the top level checks.
    typedef struct packed {
        logic              expect_header;
        logic [DEST_W-1:0] dest_bit;
    } dec_status_t;

endpackage

FILE: rtl/core/hid_descriptor_run_builder_core.sv
// HID report descriptor run builder. Descriptor bytes enter one per request on
// the s_ side, with s_tlast on the final byte, and a byte is taken in every
// cycle while the result queue has two free entries. Each data, variable Input
// item with a nonzero report count yields one mapping run (m_tuser = 0); the
// final byte also yields the bitmap size in bytes (m_tuser = 1) and returns the
// parser to its reset state. A byte's results are registered in the result
// queue and leave on the m_ side one result per cycle while m_tready is high;
// m_tlast marks the last result of a byte. Throughput is one byte per cycle
// while the queue has room; the item parser is combinational and feeds a
// four-entry result queue; a byte with two results sends them one by one.
`include "hid_descriptor_run_builder_core_defines.svh"

module hid_descriptor_run_builder_core
    import hid_drb_pkg::*;
(
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_tvalid,
    output logic               s_tready,
    input  logic [7:0]         s_tdata,  // [7:0] data_byte
    input  logic               s_tlast,  // end_of_descriptor
    output logic               m_tvalid,
    input  logic               m_tready,
    // [15:0] source_start, [31:16] dest_start, [39:32] run_length,
    // [53:40] bitmap_bytes, [55:54] zero
    output logic [TDATA_W-1:0] m_tdata,
    output logic [0:0]         m_tuser,  // [0] kind
    output logic               m_tlast   // last_of_run
);

    dec_out_t    dec_out;
    dec_status_t dec_status;
    result_t     head;
    logic        byte_accept;

    assign byte_accept = s_tvalid && s_tready;

    // Item parser.
    hid_drb_decoder u_decoder (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .byte_accept       (byte_accept),
        .data_byte         (s_tdata),
        .end_of_descriptor (s_tlast),
        .dec_out           (dec_out),
        .dec_status        (dec_status)
    );

    // Result queue between parser and output.
    hid_drb_queue u_queue (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .wr_in    (dec_out),
        .has_room (s_tready),
        .rd_valid (m_tvalid),
        .rd_ready (m_tready),
        .rd_data  (head)
    );

    // Pack the head result onto the output stream.
    assign m_tdata = {2'b00, head.bitmap_bytes, head.run_length,
                      head.dest_start, head.source_start};
    assign m_tuser = head.kind;
    assign m_tlast = head.last_of_run;

    `HDRB_ASSERT_IMPLIES(a_end_is_last, aclk, aresetn, m_tvalid && m_tuser[0], m_tlast,
        "end-of-descriptor result not marked last")
    `HDRB_ASSERT_IMPLIES(a_run_nonzero, aclk, aresetn, m_tvalid && !m_tuser[0],
        m_tdata[39:32] != 8'h00, "zero-length run emitted")
    `HDRB_ASSERT_IMPLIES(a_end_fields_zero, aclk, aresetn, m_tvalid && m_tuser[0],
        m_tdata[39:0] == 40'h0, "end result carries run fields")
    `HDRB_ASSERT_NEXT(a_end_restarts, aclk, aresetn, s_tvalid && s_tready && s_tlast,
        dec_status.expect_header && dec_status.dest_bit == '0,
        "parser not restarted after end of descriptor")

endmodule

FILE: rtl/core/hid_drb_decoder.sv
module hid_drb_decoder
    import hid_drb_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        byte_accept,
    input  logic [7:0]  data_byte,
    input  logic        end_of_descriptor,
    output dec_out_t    dec_out,
    output dec_status_t dec_status
);

    logic [7:0]         hdr_reg, hdr_next;
    logic [2:0]         rem_reg, rem_next;
    logic [1:0]         pos_reg, pos_next;
    logic [15:0]        acc_reg, acc_next;
    logic [USAGE_W-1:0] umin_reg, umin_next;
    logic [LEN_W-1:0]   rc_reg, rc_next;
    logic [DEST_W-1:0]  dest_reg, dest_next;

    logic [7:0]         eff_hdr;
    logic [15:0]        eff_val;
    logic               complete;
    logic [DEST_W:0]    bytes_sum;
    item_type_t         eff_type;

    assign eff_type = item_type_t'(eff_hdr[3:2]);

    // Item parser and local/global state update for one accepted byte.
    always_comb begin
        hdr_next  = hdr_reg;
        rem_next  = rem_reg;
        pos_next  = pos_reg;
        acc_next  = acc_reg;
        umin_next = umin_reg;
        rc_next   = rc_reg;
        dest_next = dest_reg;
        eff_hdr   = hdr_reg;
        eff_val   = acc_reg;
        complete  = 1'b0;
        bytes_sum = '0;
        dec_out   = '0;
        dec_out.run_res.kind         = KIND_RUN;
        dec_out.run_res.source_start = umin_reg;
        dec_out.run_res.dest_start   = dest_reg;
        dec_out.run_res.run_length   = rc_reg;
        dec_out.run_res.last_of_run  = !end_of_descriptor;
        dec_out.end_res.kind         = KIND_END;
        dec_out.end_res.last_of_run  = 1'b1;

        if (byte_accept) begin
            if (rem_reg == 3'd0) begin
                // Header byte: start a new item.
                hdr_next = data_byte;
                acc_next = '0;
                pos_next = '0;
                rem_next = (data_byte[1:0] == SIZE_CODE_FOUR) ? 3'd4
                                                              : {1'b0, data_byte[1:0]};
                complete = (data_byte[1:0] == 2'b00);
                eff_hdr  = data_byte;
                eff_val  = '0;
            end else begin
                // Value byte, little endian; only the low two bytes matter.
                case (pos_reg)
                    2'd0:    acc_next = acc_reg | {8'h00, data_byte};
                    2'd1:    acc_next = acc_reg | {data_byte, 8'h00};
                    default: acc_next = acc_reg;
                endcase
                pos_next = pos_reg + 2'd1;
                rem_next = rem_reg - 3'd1;
                complete = (rem_reg == 3'd1);
                eff_val  = acc_next;
            end

            // Apply a finished (or truncated) item.
            if (complete || end_of_descriptor) begin
                rem_next = '0;
                pos_next = '0;
                if (eff_hdr[7:2] == REPORT_COUNT_TAG) begin
                    rc_next = eff_val[LEN_W-1:0];
                end
                if (eff_hdr[7:2] == USAGE_MIN_TAG) begin
                    umin_next = eff_val[USAGE_W-1:0];
                end
                if (eff_type == ITEM_MAIN) begin
                    if (eff_hdr[7:2] == INPUT_TAG && !eff_val[CONST_FLAG_BIT]
                        && eff_val[VAR_FLAG_BIT] && rc_reg != '0) begin
                        dec_out.run_valid = 1'b1;
                        dest_next = dest_reg + {{(DEST_W-LEN_W){1'b0}}, rc_reg};
                    end
                    umin_next = '0;
                end
            end

            // End of descriptor: report the bitmap size and start over.
            if (end_of_descriptor) begin
                bytes_sum = {1'b0, dest_next} + (DEST_W+1)'(7);
                dec_out.end_valid            = 1'b1;
                dec_out.end_res.bitmap_bytes = bytes_sum[DEST_W:3];
                hdr_next  = '0;
                acc_next  = '0;
                umin_next = '0;
                rc_next   = '0;
                dest_next = '0;
            end
        end
    end

    // Parser state registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            hdr_reg  <= '0;
            rem_reg  <= '0;
            pos_reg  <= '0;
            acc_reg  <= '0;
            umin_reg <= '0;
            rc_reg   <= '0;
            dest_reg <= '0;
        end else begin
            hdr_reg  <= hdr_next;
            rem_reg  <= rem_next;
            pos_reg  <= pos_next;
            acc_reg  <= acc_next;
            umin_reg <= umin_next;
            rc_reg   <= rc_next;
            dest_reg <= dest_next;
        end
    end

    assign dec_status.expect_header = (rem_reg == 3'd0);
    assign dec_status.dest_bit      = dest_reg;

endmodule

FILE: rtl/core/hid_drb_queue.sv
module hid_drb_queue
    import hid_drb_pkg::*;
(
    input  logic     aclk,
    input  logic     aresetn,
    input  dec_out_t wr_in,
    output logic     has_room,
    output logic     rd_valid,
    input  logic     rd_ready,
    output result_t  rd_data
);

    result_t           entry_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [QCNT_W-1:0] count_reg;
    logic [QPTR_W-1:0] end_slot;
    logic              pop;
    logic [QCNT_W-1:0] push_cnt;

    assign pop      = rd_valid && rd_ready;
    assign push_cnt = QCNT_W'(wr_in.run_valid) + QCNT_W'(wr_in.end_valid);
    assign end_slot = wr_in.run_valid ? wr_ptr_reg + QPTR_W'(1) : wr_ptr_reg;

    // Result storage; a run always lands ahead of the end result.
    always_ff @(posedge aclk) begin
        if (wr_in.run_valid) begin
            entry_reg[wr_ptr_reg] <= wr_in.run_res;
        end
        if (wr_in.end_valid) begin
            entry_reg[end_slot] <= wr_in.end_res;
        end
    end

    // Pointers and fill count.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_reg + push_cnt[QPTR_W-1:0];
            if (pop) begin
                rd_ptr_reg <= rd_ptr_reg + QPTR_W'(1);
            end
            count_reg <= count_reg + push_cnt - QCNT_W'(pop);
        end
    end

    assign has_room = (count_reg <= QCNT_W'(QUEUE_DEPTH - 2));
    assign rd_valid = (count_reg != '0);
    assign rd_data  = entry_reg[rd_ptr_reg];

endmodule
